FILE: hw/rtl/rmf_pkg.sv
// Shared constants, register codes and control types for the RGB 3x3 median filter.
// No dependencies; every other file of the block refers to it by scoped names.
package rmf_pkg;

    localparam int MAX_WIDTH_DEF    = 2048;
    localparam int CHANNEL_BITS_DEF = 8;
    localparam int MAX_HEIGHT       = 4096;

    localparam int PORT_CHAN_BITS   = 8;
    localparam int TDATA_BITS       = 3 * PORT_CHAN_BITS;

    localparam int CFG_INDEX_BITS   = 1;
    localparam int CFG_DATA_BITS    = 13;
    localparam int WIDTH_REG_BITS   = 12;
    localparam int HEIGHT_REG_BITS  = 13;
    localparam int IN_ROW_BITS      = 13;
    localparam int OUT_ROW_BITS     = 12;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 13'd480;

    // tuser codes
    localparam logic ACTION_PIXEL = 1'b0;
    localparam logic ACTION_FLUSH = 1'b1;

    // per-beat decisions made at input time
    typedef struct packed {
        logic res;     // beat produces a result
        logic border;  // result is a border pixel (center passes through)
        logic last;    // result closes the frame
    } rmf_flags_t;

endpackage

FILE: hw/rtl/rgb_median_filter_3x3_core.sv
// Top level of the streaming RGB 3x3 median filter: line store, window, pipeline.
// Depends on rmf_pkg, rmf_line_mem, rmf_ctrl and rmf_median.
//
//  port group | dir | width | beat content
//  -----------+-----+-------+------------------------------------------------
//  cfg_*      | in  | 1/13  | register write: image_width (0), image_height (1)
//  s_*        | in  | 24+1  | pixel in: tdata red/green/blue, tuser = flush
//  m_*        | out | 24+1  | pixel out: tdata red/green/blue, tlast = frame end
//
// One beat per clock in each direction at full rate. The input beat that completes a
// window passes stage 1, the window, sort, rank and output registers in that order.
// After reset the line store is zeroed entry by entry; s_tready stays low during that
// pass, config writes are taken as usual.
// A stall on m_tready backs up the median pipeline and, once the stages are
// full, drops s_tready; nothing is lost or repeated.
// The rate is set by the single line store read per beat (one RAM, one read
// and one write port) and the shared window register.
module rgb_median_filter_3x3_core #(
    parameter int MAX_WIDTH    = rmf_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = rmf_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [rmf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [rmf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rmf_pkg::TDATA_BITS-1:0]      s_tdata,   // red_in, green_in, blue_in
    input  logic                                s_tuser,   // action
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rmf_pkg::TDATA_BITS-1:0]      m_tdata,   // red_out, green_out, blue_out
    output logic                                m_tlast    // frame_last
);

    localparam int CB  = $clog2(MAX_WIDTH);
    localparam int CHB = CHANNEL_BITS;
    localparam int PCB = rmf_pkg::PORT_CHAN_BITS;
    localparam int ENTRY_BITS = 6 * CHB;

    // line store entry: [1] upper row, [0] lower row; each [channel]
    typedef logic [1:0][2:0][CHB-1:0] entry_t;
    typedef logic [2:0][CHB-1:0]      pix_t;

    logic                 accept;
    logic [CB-1:0]        idx;
    rmf_pkg::rmf_flags_t  flags;
    logic                 clr_busy;
    logic [CB-1:0]        clr_addr;

    pix_t                 in_px;

    // stage 1: line store read in flight
    logic                 s1_v_reg;
    logic [CB-1:0]        s1_idx_reg;
    pix_t                 s1_px_reg;
    rmf_pkg::rmf_flags_t  s1_flags_reg;
    logic                 s1_fwd_reg;
    entry_t               s1_fwd_data_reg;
    logic                 s1_adv;

    logic [ENTRY_BITS-1:0] mem_rdata;
    entry_t                rd_eff;
    entry_t                wr_entry;
    logic                  mem_we;
    logic [CB-1:0]         mem_waddr;
    logic [ENTRY_BITS-1:0] mem_wdata;

    // stage 2: window holds the item waiting for the median unit
    logic [8:0][2:0][CHB-1:0] win_reg, win_next;
    logic                     s2_v_reg;
    logic                     s2_border_reg;
    logic                     s2_last_reg;
    logic                     med_ready;

    // flush beats enter as zero pixels
    assign in_px = (s_tuser == rmf_pkg::ACTION_FLUSH) ? '0 :
                   {CHB'(s_tdata[3*PCB-1:2*PCB]), CHB'(s_tdata[2*PCB-1:PCB]),
                    CHB'(s_tdata[PCB-1:0])};

    assign s1_adv   = s1_v_reg && (!s2_v_reg || med_ready);
    assign s_tready = !clr_busy && (!s1_v_reg || s1_adv);
    assign accept   = s_tvalid && s_tready;

    rmf_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .idx       (idx),
        .flags     (flags),
        .clr_busy  (clr_busy),
        .clr_addr  (clr_addr)
    );

    // read data of a column that is written back in the same cycle as its read is
    // issued comes from the forward register, not the RAM
    assign rd_eff      = s1_fwd_reg ? s1_fwd_data_reg : entry_t'(mem_rdata);
    assign wr_entry[1] = rd_eff[0];
    assign wr_entry[0] = s1_px_reg;

    assign mem_we    = clr_busy || s1_adv;
    assign mem_waddr = clr_busy ? clr_addr : s1_idx_reg;
    assign mem_wdata = clr_busy ? '0 : ENTRY_BITS'(wr_entry);

    rmf_line_mem #(
        .DATA_BITS (ENTRY_BITS),
        .DEPTH     (MAX_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (idx),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_v_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg      <= idx;
            s1_px_reg       <= in_px;
            s1_flags_reg    <= flags;
            s1_fwd_reg      <= s1_adv && (s1_idx_reg == idx);
            s1_fwd_data_reg <= wr_entry;
        end
    end

    // shift the window left and load the new column
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3]     = win_reg[r*3 + 1];
            win_next[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_next[2] = rd_eff[1];
        win_next[5] = rd_eff[0];
        win_next[8] = s1_px_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            s2_v_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            win_reg  <= win_next;
            s2_v_reg <= s1_flags_reg.res;
        end
        else if (med_ready)
        begin
            s2_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_border_reg <= s1_flags_reg.border;
            s2_last_reg   <= s1_flags_reg.last;
        end
    end

    rmf_median #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_median (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_v_reg),
        .in_ready  (med_ready),
        .win       (win_reg),
        .in_border (s2_border_reg),
        .in_last   (s2_last_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: hw/rtl/rmf_line_mem.sv
// Simple dual-port line store RAM: one write port, one registered read port.
// Takes its default depth from rmf_pkg; read returns the old contents on a same-cycle write.
module rmf_line_mem #(
    parameter int DATA_BITS = 48,
    parameter int DEPTH     = rmf_pkg::MAX_WIDTH_DEF,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/rmf_ctrl.sv
// Configuration registers, raster position counters and post-reset line store clear.
// Depends on rmf_pkg for register codes, widths and the flags struct.
module rmf_ctrl #(
    parameter int MAX_WIDTH = rmf_pkg::MAX_WIDTH_DEF,
    localparam int CB = $clog2(MAX_WIDTH)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rmf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [rmf_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 accept,
    output logic [CB-1:0]                        idx,
    output rmf_pkg::rmf_flags_t                  flags,
    output logic                                 clr_busy,
    output logic [CB-1:0]                        clr_addr
);

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WB > rmf_pkg::WIDTH_REG_BITS) ? WB : rmf_pkg::WIDTH_REG_BITS;
    localparam int HB = rmf_pkg::HEIGHT_REG_BITS;
    localparam int IRB = rmf_pkg::IN_ROW_BITS;
    localparam int ORB = rmf_pkg::OUT_ROW_BITS;

    logic [rmf_pkg::WIDTH_REG_BITS-1:0]  width_reg;
    logic [rmf_pkg::HEIGHT_REG_BITS-1:0] height_reg;

    logic [CB-1:0]  in_col_reg,  in_col_next;
    logic [IRB-1:0] in_row_reg,  in_row_next;
    logic [CB-1:0]  out_col_reg, out_col_next;
    logic [ORB-1:0] out_row_reg, out_row_next;

    logic           clr_busy_reg;
    logic [CB-1:0]  clr_addr_reg;

    logic [CW-1:0]  w_raw;
    logic [CW-1:0]  w_lim;
    logic [WB-1:0]  w_eff;
    logic [HB-1:0]  h_eff;
    logic           in_col_end;
    logic           out_col_end;
    logic           out_row_end;
    logic           res;
    logic           last;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rmf_pkg::WIDTH_RESET;
            height_reg <= rmf_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rmf_pkg::CFG_IMAGE_WIDTH:
                    width_reg <= cfg_data[rmf_pkg::WIDTH_REG_BITS-1:0];
                rmf_pkg::CFG_IMAGE_HEIGHT:
                    height_reg <= cfg_data[rmf_pkg::HEIGHT_REG_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // clamp geometry to its legal range
    always_comb
    begin
        w_raw = CW'(width_reg);
        if (w_raw == '0)
            w_lim = CW'(1);
        else if (w_raw > CW'(MAX_WIDTH))
            w_lim = CW'(MAX_WIDTH);
        else
            w_lim = w_raw;
        w_eff = WB'(w_lim);

        if (height_reg == '0)
            h_eff = HB'(1);
        else if (height_reg > HB'(rmf_pkg::MAX_HEIGHT))
            h_eff = HB'(rmf_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign in_col_end  = (WB'(in_col_reg) + WB'(1)) >= w_eff;
    assign out_col_end = (WB'(out_col_reg) + WB'(1)) >= w_eff;
    assign out_row_end = (HB'(out_row_reg) + HB'(1)) >= h_eff;

    assign res  = (in_row_reg >= IRB'(2)) || ((in_row_reg == IRB'(1)) && (in_col_reg != '0));
    assign last = out_row_end && out_col_end;

    assign idx          = in_col_reg;
    assign flags.res    = res;
    assign flags.border = (out_row_reg == '0) || out_row_end || (out_col_reg == '0) || out_col_end;
    assign flags.last   = last;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (accept)
        begin
            if (in_col_end)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end
            if (res)
            begin
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_end)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // zero the line store, one entry per cycle, after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == CB'(MAX_WIDTH - 1))
                clr_busy_reg <= 1'b0;
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign clr_busy = clr_busy_reg;
    assign clr_addr = clr_addr_reg;

endmodule

FILE: hw/rtl/rmf_median.sv
// Pipelined median-of-nine per channel plus the output register.
// Column sort, then max/med/min of ranks, then final med3. Uses rmf_pkg.
module rmf_median #(
    parameter int CHANNEL_BITS = rmf_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [8:0][2:0][CHANNEL_BITS-1:0]     win,
    input  logic                                  in_border,
    input  logic                                  in_last,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [rmf_pkg::TDATA_BITS-1:0]        m_tdata,
    output logic                                  m_tlast
);

    localparam int CB = CHANNEL_BITS;

    // returns {max, mid, min}
    function automatic logic [2:0][CB-1:0] sort3(input logic [CB-1:0] a,
                                                 input logic [CB-1:0] b,
                                                 input logic [CB-1:0] c);
        logic [CB-1:0] x, y, z, hi, lo, md;
        x  = (a < b) ? a : b;
        y  = (a < b) ? b : a;
        z  = (y < c) ? y : c;
        hi = (y < c) ? c : y;
        lo = (x < z) ? x : z;
        md = (x < z) ? z : x;
        return {hi, md, lo};
    endfunction

    // middle of three: max(min(a,b), min(max(a,b), c))
    function automatic logic [CB-1:0] med3(input logic [CB-1:0] a,
                                           input logic [CB-1:0] b,
                                           input logic [CB-1:0] c);
        logic [CB-1:0] lo, hi, m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (m < lo) ? lo : m;
    endfunction

    function automatic logic [CB-1:0] max3(input logic [CB-1:0] a,
                                           input logic [CB-1:0] b,
                                           input logic [CB-1:0] c);
        logic [CB-1:0] m;
        m = (a < b) ? b : a;
        return (m < c) ? c : m;
    endfunction

    function automatic logic [CB-1:0] min3(input logic [CB-1:0] a,
                                           input logic [CB-1:0] b,
                                           input logic [CB-1:0] c);
        logic [CB-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    logic                        a_v_reg, b_v_reg, o_v_reg;
    logic                        a_rdy, b_rdy, o_rdy;

    // [channel][column][rank]
    logic [2:0][2:0][2:0][CB-1:0] a_sort_reg;
    logic [2:0][CB-1:0]           a_ctr_reg;
    logic                         a_border_reg, a_last_reg;

    // [channel][0 max of lows, 1 med of mids, 2 min of highs]
    logic [2:0][2:0][CB-1:0]      b_val_reg;
    logic [2:0][CB-1:0]           b_ctr_reg;
    logic                         b_border_reg, b_last_reg;

    logic [2:0][CB-1:0]           o_pix_reg;
    logic                         o_last_reg;

    logic [2:0][2:0][2:0][CB-1:0] a_sort_next;
    logic [2:0][2:0][CB-1:0]      b_val_next;
    logic [2:0][CB-1:0]           o_pix_next;
    logic [2:0][CB-1:0]           med;

    assign o_rdy    = !o_v_reg || m_tready;
    assign b_rdy    = !b_v_reg || o_rdy;
    assign a_rdy    = !a_v_reg || b_rdy;
    assign in_ready = a_rdy;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                a_sort_next[k][c] = sort3(win[c][k], win[3 + c][k], win[6 + c][k]);
            end
            b_val_next[k][0] = max3(a_sort_reg[k][0][0], a_sort_reg[k][1][0],
                                    a_sort_reg[k][2][0]);
            b_val_next[k][1] = med3(a_sort_reg[k][0][1], a_sort_reg[k][1][1],
                                    a_sort_reg[k][2][1]);
            b_val_next[k][2] = min3(a_sort_reg[k][0][2], a_sort_reg[k][1][2],
                                    a_sort_reg[k][2][2]);
            med[k]        = med3(b_val_reg[k][0], b_val_reg[k][1], b_val_reg[k][2]);
            o_pix_next[k] = b_border_reg ? b_ctr_reg[k] : med[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (a_rdy)
                a_v_reg <= in_valid;
            if (b_rdy)
                b_v_reg <= a_v_reg;
            if (o_rdy)
                o_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_rdy && in_valid)
        begin
            a_sort_reg   <= a_sort_next;
            a_ctr_reg    <= win[4];
            a_border_reg <= in_border;
            a_last_reg   <= in_last;
        end
        if (b_rdy && a_v_reg)
        begin
            b_val_reg    <= b_val_next;
            b_ctr_reg    <= a_ctr_reg;
            b_border_reg <= a_border_reg;
            b_last_reg   <= a_last_reg;
        end
        if (o_rdy && b_v_reg)
        begin
            o_pix_reg  <= o_pix_next;
            o_last_reg <= b_last_reg;
        end
    end

    assign m_tvalid = o_v_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {rmf_pkg::PORT_CHAN_BITS'(o_pix_reg[2]),
                       rmf_pkg::PORT_CHAN_BITS'(o_pix_reg[1]),
                       rmf_pkg::PORT_CHAN_BITS'(o_pix_reg[0])};

endmodule

FILE: hw/rtl/rmf_checker.sv
// Port-level checks for rgb_median_filter_3x3_core, attached by bind.
// Depends on rmf_pkg for the stream data width.
module rmf_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [rmf_pkg::TDATA_BITS-1:0] m_tdata,
    input  logic                           m_tlast
);

    // beats taken in minus results given out
    logic [31:0] pending_reg;
    logic        in_beat;
    logic        out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_reg + 32'(in_beat) - 32'(out_beat);
    end

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // a result never appears without an input beat still owed one
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 32'd0)
        else $error("output beat without a pending input beat");

    // the line store clear holds off input right after reset
    a_clear_hold: assert property (@(posedge clk)
        !rst_n |=> !s_tready)
        else $error("input accepted during line store clear");

    // no output beat during or right after reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind rgb_median_filter_3x3_core rmf_checker u_rmf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: tb/tb_rgb_median_filter_3x3_core.sv
// Self-checking testbench for rgb_median_filter_3x3_core: directed table, then random frames.
// Depends on rmf_pkg and the core; holds its own line-store/window model for prediction.
`timescale 1ns / 1ps

module tb_rgb_median_filter_3x3_core;

    // ------------------------------------------------------------------
    // Types
    // ------------------------------------------------------------------
    // tdata layout, lowest bits first: red, green, blue
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        pixel_t px;
        logic   last;
    } frame_beat_t;

    typedef enum logic [1:0] {ROW_BEAT, ROW_SET_WIDTH, ROW_SET_HEIGHT} row_kind_t;

    // how a table row's output is checked
    typedef enum logic [1:0] {CHK_PREDICT, CHK_SILENT, CHK_TYPED} check_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        act;
        logic [23:0] value;     // beat pixel, or register value for a write row
        check_t      chk;
        logic [23:0] want;
        logic        want_last;
    } dir_row_t;

    localparam int LINE_DEPTH   = rmf_pkg::MAX_WIDTH_DEF;
    localparam int RANDOM_BEATS = 600;
    localparam int DRAIN_CYCLES = 12;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 1000000;

    function automatic logic [23:0] rgb(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        return {b, g, r};
    endfunction

    // ------------------------------------------------------------------
    // Directed table: 3x3 frame (one true median in the center), width and
    // height of zero acting as one, and a 2x2 frame opening with a flush beat
    // that must read as a zero pixel. Border outputs are typed in directly.
    // ------------------------------------------------------------------
    localparam dir_row_t DIRECTED [0:28] = '{
        '{ROW_SET_WIDTH,  rmf_pkg::ACTION_PIXEL, 24'd3, CHK_SILENT, 24'd0, 1'b0},
        '{ROW_SET_HEIGHT, rmf_pkg::ACTION_PIXEL, 24'd3, CHK_SILENT, 24'd0, 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_PIXEL, rgb(8'h00, 8'h00, 8'h00), CHK_SILENT,
          24'd0, 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_PIXEL, rgb(8'hFF, 8'hFF, 8'hFF), CHK_SILENT,
          24'd0, 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_PIXEL, rgb(8'h01, 8'h80, 8'hFE), CHK_SILENT,
          24'd0, 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_PIXEL, rgb(8'hFF, 8'h00, 8'h7F), CHK_SILENT,
          24'd0, 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_PIXEL, rgb(8'h12, 8'h34, 8'h56), CHK_TYPED,
          rgb(8'h00, 8'h00, 8'h00), 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_PIXEL, rgb(8'h80, 8'h01, 8'hFF), CHK_TYPED,
          rgb(8'hFF, 8'hFF, 8'hFF), 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_PIXEL, rgb(8'hAA, 8'h55, 8'h0F), CHK_TYPED,
          rgb(8'h01, 8'h80, 8'hFE), 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_PIXEL, rgb(8'h00, 8'hFF, 8'h80), CHK_TYPED,
          rgb(8'hFF, 8'h00, 8'h7F), 1'b0},
        // center pixel: median of all nine, left to the model
        '{ROW_BEAT, rmf_pkg::ACTION_PIXEL, rgb(8'h7E, 8'h81, 8'hC3), CHK_PREDICT,
          24'd0, 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_FLUSH, rgb(8'hFF, 8'hFF, 8'hFF), CHK_TYPED,
          rgb(8'h80, 8'h01, 8'hFF), 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_FLUSH, rgb(8'hAA, 8'hAA, 8'hAA), CHK_TYPED,
          rgb(8'hAA, 8'h55, 8'h0F), 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_FLUSH, rgb(8'h55, 8'h55, 8'h55), CHK_TYPED,
          rgb(8'h00, 8'hFF, 8'h80), 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_FLUSH, rgb(8'hFF, 8'h00, 8'hFF), CHK_TYPED,
          rgb(8'h7E, 8'h81, 8'hC3), 1'b1},
        '{ROW_SET_WIDTH,  rmf_pkg::ACTION_PIXEL, 24'd0, CHK_SILENT, 24'd0, 1'b0},
        '{ROW_SET_HEIGHT, rmf_pkg::ACTION_PIXEL, 24'd0, CHK_SILENT, 24'd0, 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_PIXEL, rgb(8'h5A, 8'hC3, 8'h3C), CHK_SILENT,
          24'd0, 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_FLUSH, rgb(8'hFF, 8'hFF, 8'hFF), CHK_SILENT,
          24'd0, 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_FLUSH, rgb(8'h00, 8'h00, 8'h00), CHK_TYPED,
          rgb(8'h5A, 8'hC3, 8'h3C), 1'b1},
        '{ROW_SET_WIDTH,  rmf_pkg::ACTION_PIXEL, 24'd2, CHK_SILENT, 24'd0, 1'b0},
        '{ROW_SET_HEIGHT, rmf_pkg::ACTION_PIXEL, 24'd2, CHK_SILENT, 24'd0, 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_FLUSH, rgb(8'hFF, 8'hFF, 8'hFF), CHK_SILENT,
          24'd0, 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_PIXEL, rgb(8'hFF, 8'hFF, 8'hFF), CHK_SILENT,
          24'd0, 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_PIXEL, rgb(8'h00, 8'h00, 8'h00), CHK_SILENT,
          24'd0, 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_PIXEL, rgb(8'h80, 8'h80, 8'h80), CHK_TYPED,
          rgb(8'h00, 8'h00, 8'h00), 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_FLUSH, rgb(8'h12, 8'h34, 8'h56), CHK_TYPED,
          rgb(8'hFF, 8'hFF, 8'hFF), 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_FLUSH, rgb(8'hFF, 8'hFF, 8'hFF), CHK_TYPED,
          rgb(8'h00, 8'h00, 8'h00), 1'b0},
        '{ROW_BEAT, rmf_pkg::ACTION_FLUSH, rgb(8'hFF, 8'hFF, 8'hFF), CHK_TYPED,
          rgb(8'h80, 8'h80, 8'h80), 1'b1}
    };

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                               clk;
    logic                               rst_n     = 1'b0;
    logic                               cfg_we    = 1'b0;
    logic [rmf_pkg::CFG_INDEX_BITS-1:0] cfg_index = rmf_pkg::CFG_IMAGE_WIDTH;
    logic [rmf_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [rmf_pkg::TDATA_BITS-1:0]     s_tdata   = '0;   // red_in, green_in, blue_in
    logic                               s_tuser   = rmf_pkg::ACTION_PIXEL;   // action
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [rmf_pkg::TDATA_BITS-1:0]     m_tdata;          // red_out, green_out, blue_out
    logic                               m_tlast;          // frame_last

    rgb_median_filter_3x3_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Filter model state: registers, two line stores, 3x3 window, counters
    // ------------------------------------------------------------------
    logic [rmf_pkg::WIDTH_REG_BITS-1:0]  width_reg  = rmf_pkg::WIDTH_RESET;
    logic [rmf_pkg::HEIGHT_REG_BITS-1:0] height_reg = rmf_pkg::HEIGHT_RESET;
    pixel_t                              line_upper [LINE_DEPTH];
    pixel_t                              line_lower [LINE_DEPTH];
    pixel_t                              win [3][3];     // [row][col], col 2 is newest
    logic [10:0]                         in_col  = '0;
    logic [rmf_pkg::IN_ROW_BITS-1:0]     in_row  = '0;
    logic [10:0]                         out_col = '0;
    logic [rmf_pkg::OUT_ROW_BITS-1:0]    out_row = '0;

    frame_beat_t filtered_q [$];   // filtered pixels still owed by the DUT
    int          mismatches   = 0;
    int          beats_sent   = 0;
    int          cycle_count  = 0;
    bit          frame_closed = 1'b0;
    bit          tx_steady    = 1'b0;
    bit          rx_steady    = 1'b0;

    // out-of-range registers clamp: 0 acts as 1, above the maximum acts as it
    function automatic int geo_width();
        if (width_reg == 0)
            return 1;
        return (width_reg > LINE_DEPTH) ? LINE_DEPTH : int'(width_reg);
    endfunction

    function automatic int geo_height();
        if (height_reg == 0)
            return 1;
        return (height_reg > rmf_pkg::MAX_HEIGHT) ? rmf_pkg::MAX_HEIGHT : int'(height_reg);
    endfunction

    // fifth smallest of nine: the value with at most four below it and at
    // least five at or below it
    function automatic logic [7:0] median_of_nine(input logic [71:0] v);
        int         lt;
        int         le;
        logic [7:0] res;
        res = v[7:0];
        for (int i = 0; i < 9; i++)
        begin
            lt = 0;
            le = 0;
            for (int j = 0; j < 9; j++)
            begin
                if (v[8*j +: 8] <  v[8*i +: 8]) lt++;
                if (v[8*j +: 8] <= v[8*i +: 8]) le++;
            end
            if (lt <= 4 && le >= 5)
                res = v[8*i +: 8];
        end
        return res;
    endfunction

    // Advance the window by one accepted beat; returns 1 when an output pixel
    // comes out of it. A flush beat enters as a zero pixel.
    function automatic bit slide_window(input logic act, input pixel_t px_in,
                                        output frame_beat_t res);
        int          w;
        int          h;
        int          idx;
        pixel_t      px;
        logic [71:0] reds;
        logic [71:0] greens;
        logic [71:0] blues;
        bit          emits;
        bit          border;
        w   = geo_width();
        h   = geo_height();
        px  = (act == rmf_pkg::ACTION_FLUSH) ? pixel_t'('0) : px_in;
        idx = (in_col >= LINE_DEPTH) ? LINE_DEPTH - 1 : int'(in_col);
        res = '0;
        // output starts one row and one pixel into the frame
        emits = (in_row >= 2) || (in_row == 1 && in_col >= 1);

        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2]       = line_upper[idx];
        win[1][2]       = line_lower[idx];
        win[2][2]       = px;
        line_upper[idx] = line_lower[idx];
        line_lower[idx] = px;

        // >= so that a register change mid-frame wraps the counters at once
        if (int'(in_col) + 1 >= w)
        begin
            in_col = '0;
            in_row = in_row + 1'b1;
        end
        else
            in_col = in_col + 1'b1;

        if (!emits)
            return 1'b0;

        border   = (out_row == 0) || (int'(out_row) + 1 >= h) ||
                   (out_col == 0) || (int'(out_col) + 1 >= w);
        res.last = (int'(out_row) + 1 >= h) && (int'(out_col) + 1 >= w);
        if (border)
            res.px = win[1][1];
        else
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                begin
                    reds  [8*(3*r+c) +: 8] = win[r][c].red;
                    greens[8*(3*r+c) +: 8] = win[r][c].green;
                    blues [8*(3*r+c) +: 8] = win[r][c].blue;
                end
            res.px.red   = median_of_nine(reds);
            res.px.green = median_of_nine(greens);
            res.px.blue  = median_of_nine(blues);
        end

        // frame end returns every counter to zero, so the next beat starts a frame
        if (res.last)
        begin
            in_col  = '0;
            in_row  = '0;
            out_col = '0;
            out_row = '0;
        end
        else if (int'(out_col) + 1 >= w)
        begin
            out_col = '0;
            out_row = out_row + 1'b1;
        end
        else
            out_col = out_col + 1'b1;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // channel values lean toward the extremes and a narrow band to force ties
    function automatic logic [7:0] random_level();
        case ($urandom_range(0, 4))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'($urandom_range(120, 136));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        p.red   = random_level();
        p.green = random_level();
        p.blue  = random_level();
        return p;
    endfunction

    // append a pixel to the owed list, oldest first
    function automatic void owe_pixel(input frame_beat_t fb);
        filtered_q = {filtered_q, fb};
    endfunction

    // register write; the model takes the value at the same edge
    task automatic write_reg(input logic [rmf_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [rmf_pkg::CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == rmf_pkg::CFG_IMAGE_WIDTH)
            width_reg = value[rmf_pkg::WIDTH_REG_BITS-1:0];
        else
            height_reg = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending and wait until every owed pixel has come out
    task automatic hold_for_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (filtered_q.size() != 0);
    endtask

    // idle point for register writes: beats that owe nothing may still be in
    // the median pipeline when the last owed pixel leaves
    task automatic settle();
        hold_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One input beat: random gap, handshake, then model step at the accepting edge.
    task automatic send_beat(input logic act, input pixel_t px, input check_t chk,
                             input pixel_t want, input logic want_last);
        frame_beat_t filt;
        bit          emits;
        int          gap;
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= px;
        @(posedge clk);
        while (!s_tready) @(posedge clk);

        emits = slide_window(act, px, filt);
        if (emits && filt.last)
            frame_closed = 1'b1;
        case (chk)
            CHK_PREDICT:
                if (emits)
                    owe_pixel(filt);
            CHK_TYPED:
            begin
                filt.px   = want;
                filt.last = want_last;
                owe_pixel(filt);
            end
            default: ;
        endcase
        beats_sent++;
    endtask

    task automatic feed(input logic act, input pixel_t px);
        send_beat(act, px, CHK_PREDICT, pixel_t'('0), 1'b0);
    endtask

    // flush beats until the frame's last pixel comes out; realigns the counters
    task automatic finish_frame();
        frame_closed = 1'b0;
        while (!frame_closed)
            feed(rmf_pkg::ACTION_FLUSH, random_pixel());
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, compare each beat with the oldest owed pixel
    // ------------------------------------------------------------------
    initial
    begin : pixel_sink
        int          stall;
        pixel_t      got;
        frame_beat_t want;
        forever
        begin
            stall = rx_steady ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);

            got = m_tdata;
            if (filtered_q.size() == 0)
            begin
                $error("output beat with nothing owed: tdata %h, tlast %b", m_tdata, m_tlast);
                mismatches++;
            end
            else
            begin
                want = filtered_q.pop_front();
                if (got.red !== want.px.red)
                begin
                    $error("red_out: expected %0d, got %0d", want.px.red, got.red);
                    mismatches++;
                end
                if (got.green !== want.px.green)
                begin
                    $error("green_out: expected %0d, got %0d", want.px.green, got.green);
                    mismatches++;
                end
                if (got.blue !== want.px.blue)
                begin
                    $error("blue_out: expected %0d, got %0d", want.px.blue, got.blue);
                    mismatches++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("frame_last: expected %0d, got %0d", want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // watchdog; also covers the line-store clearing pass after reset
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        dir_row_t row;
        int       w;
        int       h;
        int       pick;
        int       random_start;
        bit       wide_done;
        bit       pressure_done;

        wide_done     = 1'b0;
        pressure_done = 1'b0;
        for (int i = 0; i < LINE_DEPTH; i++)
        begin
            line_upper[i] = '0;
            line_lower[i] = '0;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                win[r][c] = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; s_tready stays low until the clear pass is done
        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            row = DIRECTED[i];
            case (row.kind)
                ROW_SET_WIDTH:
                begin
                    settle();
                    write_reg(rmf_pkg::CFG_IMAGE_WIDTH,
                              row.value[rmf_pkg::CFG_DATA_BITS-1:0]);
                end
                ROW_SET_HEIGHT:
                begin
                    settle();
                    write_reg(rmf_pkg::CFG_IMAGE_HEIGHT,
                              row.value[rmf_pkg::CFG_DATA_BITS-1:0]);
                end
                default:
                    send_beat(row.act, pixel_t'(row.value), row.chk,
                              pixel_t'(row.want), row.want_last);
            endcase
        end

        // random frames; one phase per loop pass
        random_start = beats_sent;
        while (beats_sent - random_start < RANDOM_BEATS)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            pick      = $urandom_range(0, 15);

            if (!wide_done && beats_sent - random_start >= RANDOM_BEATS / 2)
            begin
                // width register above max clamps to the full line, height 0 acts
                // as 1; part of a row, then a narrow width wraps the column at once
                wide_done = 1'b1;
                settle();
                write_reg(rmf_pkg::CFG_IMAGE_WIDTH, 13'd4095);
                write_reg(rmf_pkg::CFG_IMAGE_HEIGHT, 13'd0);
                repeat ($urandom_range(20, 60))
                    feed(rmf_pkg::ACTION_PIXEL, random_pixel());
                settle();
                write_reg(rmf_pkg::CFG_IMAGE_WIDTH, 13'($urandom_range(1, 8)));
                finish_frame();
            end
            else if (pick <= 1 || pick == 4)
            begin
                // partial frame, then a register change mid-frame
                settle();
                if (pick == 0)
                begin
                    case ($urandom_range(0, 5))
                        0:       write_reg(rmf_pkg::CFG_IMAGE_WIDTH, 13'd0);
                        1:       write_reg(rmf_pkg::CFG_IMAGE_WIDTH, 13'd1);
                        2:       write_reg(rmf_pkg::CFG_IMAGE_WIDTH, 13'd2048);
                        3:       write_reg(rmf_pkg::CFG_IMAGE_WIDTH, 13'd4095);
                        4:       write_reg(rmf_pkg::CFG_IMAGE_WIDTH, 13'h1000); // bit 12 dropped
                        default: write_reg(rmf_pkg::CFG_IMAGE_WIDTH,
                                           13'($urandom_range(2049, 4094)));
                    endcase
                    write_reg(rmf_pkg::CFG_IMAGE_HEIGHT, 13'($urandom_range(1, 3)));
                end
                else if (pick == 1)
                begin
                    case ($urandom_range(0, 3))
                        0:       write_reg(rmf_pkg::CFG_IMAGE_HEIGHT, 13'd0);
                        1:       write_reg(rmf_pkg::CFG_IMAGE_HEIGHT, 13'd4096);
                        2:       write_reg(rmf_pkg::CFG_IMAGE_HEIGHT, 13'd8191);
                        default: write_reg(rmf_pkg::CFG_IMAGE_HEIGHT,
                                           13'($urandom_range(4097, 8190)));
                    endcase
                    write_reg(rmf_pkg::CFG_IMAGE_WIDTH, 13'($urandom_range(1, 6)));
                end
                else
                begin
                    write_reg(rmf_pkg::CFG_IMAGE_WIDTH, 13'($urandom_range(1, 8)));
                    write_reg(rmf_pkg::CFG_IMAGE_HEIGHT, 13'($urandom_range(1, 5)));
                end
                repeat ($urandom_range(1, 40))
                    feed(($urandom_range(0, 4) == 0) ? rmf_pkg::ACTION_FLUSH :
                                                       rmf_pkg::ACTION_PIXEL,
                         random_pixel());
                settle();
                if (pick == 1)
                    write_reg(rmf_pkg::CFG_IMAGE_HEIGHT, 13'($urandom_range(1, 5)));
                else
                    write_reg(rmf_pkg::CFG_IMAGE_WIDTH, 13'($urandom_range(1, 8)));
                finish_frame();
            end
            else
            begin
                // well-formed frame; an occasional flush beat inside is a zero pixel
                settle();
                w = (pick < 4) ? $urandom_range(11, 40) : $urandom_range(1, 10);
                h = $urandom_range(1, 6);
                write_reg(rmf_pkg::CFG_IMAGE_WIDTH, 13'(w));
                write_reg(rmf_pkg::CFG_IMAGE_HEIGHT, 13'(h));
                for (int p = 0; p < w * h; p++)
                begin
                    // mid-frame pause until the output side has caught up
                    if (p == (w * h) / 2 && (!pressure_done || $urandom_range(0, 9) == 0))
                    begin
                        hold_for_results();
                        pressure_done = 1'b1;
                    end
                    feed(($urandom_range(0, 19) == 0) ? rmf_pkg::ACTION_FLUSH :
                                                        rmf_pkg::ACTION_PIXEL,
                         random_pixel());
                end
                finish_frame();
            end
        end

        hold_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/rmf_pkg.sv
hw/rtl/rmf_line_mem.sv
hw/rtl/rmf_ctrl.sv
hw/rtl/rmf_median.sv
hw/rtl/rgb_median_filter_3x3_core.sv
hw/rtl/rmf_checker.sv
tb/tb_rgb_median_filter_3x3_core.sv
